### src/lc_pkg.sv
// ----------------------------------------------------------------------------
// lc_pkg
// Shared types and constants for the linear convolution block.
// ----------------------------------------------------------------------------
package lc_pkg;

  localparam int MAX_LEN      = 32;
  localparam int SAMPLE_WIDTH = 16;

  localparam int CFG_LEN_W   = 6;
  localparam int POS_W       = 5;
  localparam int SAMPLE_IN_W = 16;
  localparam int OP_W        = 2;
  localparam int OUT_INDEX_W = 6;
  localparam int OUT_VALUE_W = 37;

  localparam logic [OP_W-1:0] OP_LOAD_A  = 2'd0;
  localparam logic [OP_W-1:0] OP_LOAD_B  = 2'd1;
  localparam logic [OP_W-1:0] OP_COMPUTE = 2'd2;

  localparam logic REG_LEN_A = 1'b0;
  localparam logic REG_LEN_B = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WAIT,
    ST_RUN
  } lc_state_t;

  // travels with each product term down the pipeline
  typedef struct packed {
    logic                   first;
    logic                   last;
    logic                   run_end;
    logic [OUT_INDEX_W-1:0] index;
  } lc_tag_t;

  typedef struct packed {
    logic    load_a;
    logic    load_b;
    logic    issue;
    lc_tag_t tag;
  } lc_cmd_t;

  typedef struct packed {
    logic dp_idle;
  } lc_status_t;

endpackage

### src/lc_ctrl.sv
// ----------------------------------------------------------------------------
// lc_ctrl
// Sequencer: accepts transactions, walks output and term indexes, issues one
// multiply-accumulate term per cycle to the datapath, pausing between outputs.
// ----------------------------------------------------------------------------
module lc_ctrl
  import lc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [OP_W-1:0]      op,
  input  logic [CFG_LEN_W-1:0] len_a,
  input  logic [CFG_LEN_W-1:0] len_b,
  input  lc_status_t           status,
  output lc_cmd_t              cmd,
  output logic [(MAX_LEN > 1 ? $clog2(MAX_LEN) : 1)-1:0] addr_a,
  output logic [(MAX_LEN > 1 ? $clog2(MAX_LEN) : 1)-1:0] addr_b
);

  localparam int AW    = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int LEN_W = $clog2(MAX_LEN + 1);
  localparam int IDX_W = $clog2(2 * MAX_LEN);

  lc_state_t        state, state_next;
  logic [IDX_W-1:0] i, i_next;
  logic [IDX_W-1:0] j, j_next;
  logic [IDX_W-1:0] jend, jend_next;
  logic             first, first_next;

  logic [LEN_W-1:0] na, nb;
  logic [IDX_W-1:0] total_m1;
  logic [IDX_W-1:0] jlo, jhi;
  logic [IDX_W-1:0] diff;
  logic [31:0]      idx_ext;
  logic             accept;

  always_comb begin
    if (len_a == '0) na = LEN_W'(1);
    else if (32'(len_a) > 32'(MAX_LEN)) na = LEN_W'(MAX_LEN);
    else na = LEN_W'(len_a);
    if (len_b == '0) nb = LEN_W'(1);
    else if (32'(len_b) > 32'(MAX_LEN)) nb = LEN_W'(MAX_LEN);
    else nb = LEN_W'(len_b);
  end

  assign total_m1 = IDX_W'(na - LEN_W'(1)) + IDX_W'(nb - LEN_W'(1));
  assign jlo      = (i >= IDX_W'(na)) ? (i - IDX_W'(na) + IDX_W'(1)) : '0;
  assign jhi      = (i < IDX_W'(nb)) ? i : (IDX_W'(nb) - IDX_W'(1));
  assign diff     = i - j;
  assign addr_a   = diff[AW-1:0];
  assign addr_b   = j[AW-1:0];
  assign idx_ext  = 32'(i);

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      i     <= '0;
      j     <= '0;
      jend  <= '0;
      first <= 1'b0;
    end else begin
      state <= state_next;
      i     <= i_next;
      j     <= j_next;
      jend  <= jend_next;
      first <= first_next;
    end
  end

  always_comb begin
    state_next       = state;
    i_next           = i;
    j_next           = j;
    jend_next        = jend;
    first_next       = first;
    cmd              = '0;
    cmd.tag.first    = first;
    cmd.tag.last     = (j == jend);
    cmd.tag.run_end  = (i == total_m1);
    cmd.tag.index    = idx_ext[OUT_INDEX_W-1:0];
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          cmd.load_a = (op == OP_LOAD_A);
          cmd.load_b = (op == OP_LOAD_B);
          if (op == OP_COMPUTE) begin
            i_next     = '0;
            state_next = ST_WAIT;
          end
        end
      end
      ST_WAIT: begin
        if (status.dp_idle) begin
          j_next     = jlo;
          jend_next  = jhi;
          first_next = 1'b1;
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        cmd.issue  = 1'b1;
        first_next = 1'b0;
        if (j == jend) begin
          if (i == total_m1) begin
            state_next = ST_IDLE;
          end else begin
            i_next     = i + IDX_W'(1);
            state_next = ST_WAIT;
          end
        end else begin
          j_next = j + IDX_W'(1);
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  a_term_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RUN) |-> (j <= jend && j <= i))
    else $error("term index beyond its range");

  a_issue_waits_idle: assert property (@(posedge clk) disable iff (rst)
    (state == ST_WAIT && !status.dp_idle) |=> (state == ST_WAIT))
    else $error("output started before datapath drained");

endmodule

### src/lc_dp.sv
// ----------------------------------------------------------------------------
// lc_dp
// Datapath: sample stores, registered reads, multiplier, accumulator and
// output register.
// ----------------------------------------------------------------------------
module lc_dp
  import lc_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst,
  input  lc_cmd_t                       cmd,
  input  logic [(MAX_LEN > 1 ? $clog2(MAX_LEN) : 1)-1:0] addr_a,
  input  logic [(MAX_LEN > 1 ? $clog2(MAX_LEN) : 1)-1:0] addr_b,
  input  logic [POS_W-1:0]              position,
  input  logic signed [SAMPLE_IN_W-1:0] sample,
  output lc_status_t                    status,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [OUT_INDEX_W-1:0]        out_index,
  output logic [OUT_VALUE_W-1:0]        out_value,
  output logic                          out_last
);

  localparam int AW       = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int PROD_W   = 2 * SAMPLE_WIDTH;
  localparam int ACC_CALC = PROD_W + $clog2(MAX_LEN) + 1;
  localparam int ACC_W    = (ACC_CALC > OUT_VALUE_W) ? ACC_CALC : OUT_VALUE_W;

  logic signed [SAMPLE_WIDTH-1:0] store_a [MAX_LEN];
  logic signed [SAMPLE_WIDTH-1:0] store_b [MAX_LEN];

  logic signed [SAMPLE_WIDTH-1:0] wr_sample;
  logic [31:0]                    wr_addr_ext;
  logic [AW-1:0]                  wr_addr;
  logic                           pos_ok;

  logic                           v1, v2;
  lc_tag_t                        tag1, tag2;
  logic signed [SAMPLE_WIDTH-1:0] a_q, b_q;
  logic signed [PROD_W-1:0]       prod;
  logic signed [ACC_W-1:0]        acc, acc_sum;

  assign wr_sample   = SAMPLE_WIDTH'(sample);
  assign wr_addr_ext = 32'(position);
  assign wr_addr     = wr_addr_ext[AW-1:0];
  assign pos_ok      = (wr_addr_ext < 32'(MAX_LEN));

  always_ff @(posedge clk) begin
    if (cmd.load_a && pos_ok) store_a[wr_addr] <= wr_sample;
    if (cmd.load_b && pos_ok) store_b[wr_addr] <= wr_sample;
    a_q <= store_a[addr_a];
    b_q <= store_b[addr_b];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= cmd.issue;
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    tag1 <= cmd.tag;
    tag2 <= tag1;
    prod <= a_q * b_q;
  end

  assign acc_sum = tag2.first ? ACC_W'(prod) : (acc + ACC_W'(prod));

  always_ff @(posedge clk) begin
    if (v2) acc <= acc_sum;
    if (v2 && tag2.last) begin
      out_index <= tag2.index;
      out_value <= acc_sum[OUT_VALUE_W-1:0];
      out_last  <= tag2.run_end;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (v2 && tag2.last) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  assign status.dp_idle = !v1 && !v2 && (!m_tvalid || m_tready);

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (v2 && tag2.last) |-> (!m_tvalid || m_tready))
    else $error("result register overwritten before transaction");

  a_pipe_advance: assert property (@(posedge clk) disable iff (rst)
    v1 |=> v2)
    else $error("term lost between read and multiply stages");

endmodule

### src/linear_convolution.sv
// ----------------------------------------------------------------------------
// linear_convolution
// Direct full linear convolution of two stored Q1.15 sequences.
// ----------------------------------------------------------------------------
// Load transactions (operation 0 or 1) write one sample of A or B. A compute
// transaction (operation 2) returns len_a+len_b-1 results in index order,
// the last one flagged by m_tlast. One shared multiply-accumulate unit
// handles one term per cycle while a result's terms are issued, and waits
// for the datapath to drain before the next result. Result i has 1 up to
// min(len_a, len_b) terms, which pass through the store read, multiplier and
// accumulator stages. Lengths outside 1..MAX_LEN are clamped; loads at
// positions at or above MAX_LEN are dropped. The next transaction is
// accepted while the final result waits.
// ----------------------------------------------------------------------------
module linear_convolution
  import lc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // operation[1:0], position[6:2], sample[22:7]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // out_index[5:0], out_value[42:6]
  output logic        m_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

  logic [CFG_LEN_W-1:0]   len_a, len_b;
  logic                   cfg_wr;
  lc_cmd_t                cmd;
  lc_status_t             status;
  logic [AW-1:0]          addr_a, addr_b;
  logic [OUT_INDEX_W-1:0] out_index;
  logic [OUT_VALUE_W-1:0] out_value;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      len_a <= CFG_LEN_W'(16);
      len_b <= CFG_LEN_W'(16);
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_LEN_A: len_a <= pwdata[CFG_LEN_W-1:0];
        REG_LEN_B: len_b <= pwdata[CFG_LEN_W-1:0];
        default:   len_a <= len_a;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_LEN_A: prdata = 32'(len_a);
      REG_LEN_B: prdata = 32'(len_b);
      default:   prdata = '0;
    endcase
  end

  lc_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .op      (s_tdata[1:0]),
    .len_a   (len_a),
    .len_b   (len_b),
    .status  (status),
    .cmd     (cmd),
    .addr_a  (addr_a),
    .addr_b  (addr_b)
  );

  lc_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .addr_a   (addr_a),
    .addr_b   (addr_b),
    .position (s_tdata[6:2]),
    .sample   ($signed(s_tdata[22:7])),
    .status   (status),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .out_index(out_index),
    .out_value(out_value),
    .out_last (m_tlast)
  );

  assign m_tdata = {5'b0, out_value, out_index};

endmodule

### bench/linear_convolution_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// linear_convolution_test
// Self-checking bench for the linear convolution block. Samples are loaded
// over the slave stream, lengths set over APB, and every compute run is
// predicted in the bench and checked result by result on the master stream.
// Both stream sides idle at random, with stretches of back-to-back traffic.
// ----------------------------------------------------------------------------
module linear_convolution_test;
  import lc_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int DEPTH = 32;
  localparam int DRAIN_CYCLES = 16;

  typedef struct {
    logic [OUT_INDEX_W-1:0]        index;
    logic signed [OUT_VALUE_W-1:0] value;
    logic                          last;
  } conv_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;    // operation[1:0], position[6:2], sample[22:7]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [47:0] m_tdata;         // out_index[5:0], out_value[42:6]
  logic        m_tlast;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  // bench copy of the block's state
  logic signed [SAMPLE_IN_W-1:0] seq_a [DEPTH];
  logic signed [SAMPLE_IN_W-1:0] seq_b [DEPTH];
  logic [CFG_LEN_W-1:0]          len_a_reg = 6'd16;
  logic [CFG_LEN_W-1:0]          len_b_reg = 6'd16;

  conv_result_t pending_outputs [$];
  int           mismatches = 0;
  int           items_sent = 0;
  bit           no_idle = 1'b0;

  linear_convolution u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #2 clk = ~clk;

  initial begin
    #10_000_000;
    $display("[linear_convolution] ERROR");
    $finish;
  end

  function automatic int clamp_len(logic [CFG_LEN_W-1:0] r);
    if (r < 1) return 1;
    if (r > DEPTH) return DEPTH;
    return int'(r);
  endfunction

  function automatic void convolve_and_queue();
    int           na;
    int           nb;
    int           total;
    longint       acc;
    conv_result_t res;
    na    = clamp_len(len_a_reg);
    nb    = clamp_len(len_b_reg);
    total = na + nb - 1;
    for (int i = 0; i < total; i++) begin
      acc = 0;
      for (int j = 0; j < nb; j++) begin
        if (j <= i && i - j < na) acc += longint'(seq_a[i-j]) * longint'(seq_b[j]);
      end
      res.index = i[OUT_INDEX_W-1:0];
      res.value = acc[OUT_VALUE_W-1:0];
      res.last  = (i + 1 == total);
      pending_outputs = {pending_outputs, res};
    end
  endfunction

  function automatic void apply_item(logic [23:0] item);
    logic [OP_W-1:0]               op;
    logic [POS_W-1:0]              pos;
    logic signed [SAMPLE_IN_W-1:0] smp;
    op  = item[1:0];
    pos = item[6:2];
    smp = item[22:7];
    case (op)
      OP_LOAD_A:  seq_a[pos] = smp;
      OP_LOAD_B:  seq_b[pos] = smp;
      OP_COMPUTE: convolve_and_queue();
      default: ;
    endcase
  endfunction

  // results are popped before new items are predicted in the same cycle
  always @(posedge clk) begin
    conv_result_t want;
    logic signed [OUT_VALUE_W-1:0] got_value;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        got_value = m_tdata[42:6];
        if (pending_outputs.size() == 0) begin
          $error("unexpected result: out_index %0d out_value %0d",
                 m_tdata[5:0], got_value);
          mismatches++;
        end else begin
          want = pending_outputs.pop_front();
          if (m_tdata[5:0] !== want.index) begin
            $error("out_index expected %0d got %0d", want.index, m_tdata[5:0]);
            mismatches++;
          end
          if (got_value !== want.value) begin
            $error("out_value expected %0d got %0d", want.value, got_value);
            mismatches++;
          end
          if (m_tlast !== want.last) begin
            $error("out_last expected %0d got %0d", want.last, m_tlast);
            mismatches++;
          end
        end
      end
      if (s_tvalid && s_tready) apply_item(s_tdata);
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= no_idle || ($urandom_range(99) >= 19);
    end
  end

  task automatic send_item(logic [OP_W-1:0] op, logic [POS_W-1:0] pos,
                           logic [SAMPLE_IN_W-1:0] smp);
    if (!no_idle) begin
      while ($urandom_range(99) < 19) begin
        s_tvalid <= 1'b0;
        @(posedge clk);
      end
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {1'b0, smp, pos, op};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    if (op != OP_UNUSED) items_sent++;
  endtask

  task automatic compute();
    send_item(OP_COMPUTE, POS_W'($urandom), SAMPLE_IN_W'($urandom));
  endtask

  task automatic wait_idle();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending_outputs.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(logic sel, logic [CFG_LEN_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {sel, 2'b00};
    pwdata  <= {26'($urandom), value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (sel == REG_LEN_B) len_b_reg = value;
    else len_a_reg = value;
    @(posedge clk);
  endtask

  task automatic set_lengths(logic [CFG_LEN_W-1:0] la, logic [CFG_LEN_W-1:0] lb);
    wait_idle();
    cfg_write(REG_LEN_A, la);
    cfg_write(REG_LEN_B, lb);
  endtask

  function automatic logic [CFG_LEN_W-1:0] pick_len();
    case ($urandom_range(9))
      0:       return 6'd0;
      1:       return 6'd32;
      2:       return CFG_LEN_W'($urandom_range(33, 63));
      3:       return 6'd1;
      4:       return CFG_LEN_W'($urandom_range(9, 31));
      default: return CFG_LEN_W'($urandom_range(2, 8));
    endcase
  endfunction

  function automatic logic [SAMPLE_IN_W-1:0] pick_sample();
    case ($urandom_range(7))
      0:       return 16'h8000;
      1:       return 16'h7fff;
      default: return SAMPLE_IN_W'($urandom);
    endcase
  endfunction

  // fills every entry of both stores, so no later run reads an unwritten one
  task automatic test_reset_lengths();
    for (int p = 0; p < DEPTH; p++) begin
      send_item(OP_LOAD_A, POS_W'(p), 16'h8000);
      send_item(OP_LOAD_B, POS_W'(p), 16'h8000);
    end
    compute();
  endtask

  task automatic test_length_limits();
    set_lengths(6'd32, 6'd32);
    compute();
    set_lengths(6'd63, 6'd33);
    compute();
    set_lengths(6'd0, 6'd0);
    compute();
    set_lengths(6'd32, 6'd1);
    send_item(OP_LOAD_B, 5'd0, 16'h7fff);
    compute();
  endtask

  task automatic test_mixed_signs();
    set_lengths(6'd3, 6'd2);
    send_item(OP_LOAD_A, 5'd0, 16'h7fff);
    send_item(OP_LOAD_A, 5'd1, 16'hffff);
    send_item(OP_LOAD_A, 5'd2, 16'h0001);
    send_item(OP_LOAD_B, 5'd0, 16'h8000);
    send_item(OP_LOAD_B, 5'd1, 16'h7fff);
    compute();
    send_item(OP_UNUSED, 5'd31, 16'hffff);
    send_item(OP_UNUSED, 5'd0, 16'h0000);
    compute();
  endtask

  task automatic test_random_runs();
    int start;
    int phase;
    int na;
    int nb;
    start = items_sent;
    phase = 0;
    while (items_sent - start < 100) begin
      set_lengths(pick_len(), pick_len());
      na      = clamp_len(len_a_reg);
      nb      = clamp_len(len_b_reg);
      no_idle = (phase % 5 == 2);
      repeat ($urandom_range(1, 3)) begin
        repeat ($urandom_range(0, 6)) begin
          if ($urandom_range(1)) begin
            send_item(OP_LOAD_A, ($urandom_range(9) == 0) ? POS_W'($urandom)
                                  : POS_W'($urandom_range(na - 1)), pick_sample());
          end else begin
            send_item(OP_LOAD_B, ($urandom_range(9) == 0) ? POS_W'($urandom)
                                  : POS_W'($urandom_range(nb - 1)), pick_sample());
          end
        end
        if ($urandom_range(7) == 0)
          send_item(OP_UNUSED, POS_W'($urandom), SAMPLE_IN_W'($urandom));
        if ($urandom_range(9) != 0) compute();
      end
      phase++;
    end
    no_idle = 1'b0;
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_lengths();
    test_length_limits();
    test_mixed_signs();
    test_random_runs();
    wait_idle();
    if (mismatches == 0) begin
      $display("[linear_convolution] OK");
    end else begin
      $display("[linear_convolution] ERROR");
    end
    $finish;
  end

endmodule
